@@ rtl/mmec_pkg.sv @@
package mmec_pkg;

   // Fixed field widths of the ports.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int COUNT_W     = 16;
   localparam int MODE_W      = 2;
   localparam int ROWCOUNT_W  = 13;
   localparam int COLCOUNT_W  = 13;
   localparam int COL_W       = 12;

   // Depth of the column queue between the accumulator and the row mapper.
   localparam int QUEUE_DEPTH = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_COLUMN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACE_MODE         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAT_LINE_ENABLE   = 3'd4;

   // Register reset values.
   localparam logic [COUNT_W-1:0]    SPC_RESET  = 16'd1;
   localparam logic [MODE_W-1:0]     MODE_RESET = 2'd0;
   localparam logic [ROWCOUNT_W-1:0] ROWS_RESET = 13'd256;
   localparam logic [COLCOUNT_W-1:0] COLS_RESET = 13'd512;

   // Largest usable column count.
   localparam logic [COLCOUNT_W-1:0] MAX_COLUMNS = 13'd4096;

   // Decoded trace mode shared by the accumulator and the row mapper.
   typedef struct packed {
      logic stereo;
      logic left_right;
      logic flat_enable;
   } mode_type;

endpackage

@@ rtl/minmax_envelope_column.sv @@
// Channel    | Direction | Handshake              | Contents
// req_*      | in        | req_valid / req_ready  | one mid and one side sample
// rsp_*      | out       | rsp_valid / rsp_ready  | column index and two row spans
// csr_*      | in        | csr_write_enable       | register index and write data
//
// One request is taken per cycle while the column queue has room; the
// accumulator itself never holds a request back.
// A column result passes from the queue through the mapping stages in order:
// queue pop with clamp, multiply, then round and offset into the output register.
// Reset is synchronous and active high; it restores the register defaults,
// clears the extremes, the sample count and the column index, and empties
// the queue and the mapping pipeline.
// A stalled response channel fills the pipeline and then the queue; only then
// does req_ready drop, and requests that do not close a column still wait.

module minmax_envelope_column #(
   parameter int SAMPLE_BITS = 16,
   parameter int ROW_BITS    = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_mid_sample,
   input  logic signed [SAMPLE_BITS-1:0]        req_side_sample,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mmec_pkg::COL_W-1:0]           rsp_column_index,
   output logic                                 rsp_primary_drawn,
   output logic [ROW_BITS-1:0]                  rsp_primary_row_low,
   output logic [ROW_BITS-1:0]                  rsp_primary_row_high,
   output logic                                 rsp_secondary_drawn,
   output logic [ROW_BITS-1:0]                  rsp_secondary_row_low,
   output logic [ROW_BITS-1:0]                  rsp_secondary_row_high,

   input  logic                                 csr_write_enable,
   input  logic [mmec_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mmec_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // One queue entry holds the four extremes of a finished column and its index.
   localparam int TW = SAMPLE_BITS + 1;
   localparam int QW = 4 * TW + mmec_pkg::COL_W;

   // Configuration registers.
   logic [mmec_pkg::COUNT_W-1:0]    spc_ff, spc_in;
   logic [mmec_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic [mmec_pkg::ROWCOUNT_W-1:0] rows_ff, rows_in;
   logic [mmec_pkg::COLCOUNT_W-1:0] cols_ff, cols_in;
   logic                            flat_ff, flat_in;

   mmec_pkg::mode_type mode;

   logic          req_fire;
   logic          push_valid;
   logic [QW-1:0] push_data;
   logic          q_not_full, q_not_empty, q_pop;
   logic [QW-1:0] q_data;

   always_comb begin
      spc_in  = spc_ff;
      mode_in = mode_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      flat_in = flat_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mmec_pkg::CSR_SAMPLES_PER_COLUMN: begin
               spc_in = csr_write_data;
            end
            mmec_pkg::CSR_TRACE_MODE: begin
               mode_in = csr_write_data[mmec_pkg::MODE_W-1:0];
            end
            mmec_pkg::CSR_ROW_COUNT: begin
               rows_in = csr_write_data[mmec_pkg::ROWCOUNT_W-1:0];
            end
            mmec_pkg::CSR_COLUMN_COUNT: begin
               cols_in = csr_write_data[mmec_pkg::COLCOUNT_W-1:0];
            end
            mmec_pkg::CSR_FLAT_LINE_ENABLE: begin
               flat_in = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff  <= mmec_pkg::SPC_RESET;
         mode_ff <= mmec_pkg::MODE_RESET;
         rows_ff <= mmec_pkg::ROWS_RESET;
         cols_ff <= mmec_pkg::COLS_RESET;
         flat_ff <= 1'b1;
      end else begin
         spc_ff  <= spc_in;
         mode_ff <= mode_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         flat_ff <= flat_in;
      end
   end

   // Bit 1 of the mode selects left/right sums; the unused code behaves the same way.
   assign mode.stereo      = (mode_ff != '0);
   assign mode.left_right  = mode_ff[1];
   assign mode.flat_enable = flat_ff;

   // A full queue holds off every request, since any request may close a column.
   assign req_ready = q_not_full;
   assign req_fire  = req_valid && req_ready;

   mmec_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .fire               (req_fire),
      .mid_sample         (req_mid_sample),
      .side_sample        (req_side_sample),
      .samples_per_column (spc_ff),
      .column_count       (cols_ff),
      .mode               (mode),
      .push_valid         (push_valid),
      .push_data          (push_data)
   );

   mmec_queue #(
      .WIDTH (QW),
      .DEPTH (mmec_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   mmec_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ROW_BITS    (ROW_BITS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_not_empty),
      .q_data                 (q_data),
      .q_pop                  (q_pop),
      .row_count              (rows_ff),
      .mode                   (mode),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_column_index       (rsp_column_index),
      .rsp_primary_drawn      (rsp_primary_drawn),
      .rsp_primary_row_low    (rsp_primary_row_low),
      .rsp_primary_row_high   (rsp_primary_row_high),
      .rsp_secondary_drawn    (rsp_secondary_drawn),
      .rsp_secondary_row_low  (rsp_secondary_row_low),
      .rsp_secondary_row_high (rsp_secondary_row_high)
   );

   // The mapping is monotonic and every column holds at least one sample,
   // so a drawn span never runs backward.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_primary_drawn |-> rsp_primary_row_low <= rsp_primary_row_high)
      else $error("primary span runs backward");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_secondary_drawn |-> rsp_secondary_row_low <= rsp_secondary_row_high)
      else $error("secondary span runs backward");

   // A suppressed trace reports both rows as zero; this check covers the case where both traces are suppressed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_primary_drawn && !rsp_secondary_drawn |->
         rsp_primary_row_low == '0 && rsp_primary_row_high == '0 &&
         rsp_secondary_row_low == '0 && rsp_secondary_row_high == '0)
      else $error("suppressed span carries rows");

   // The queue is popped only when it holds an entry.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("column queue popped while empty");

endmodule

@@ rtl/mmec_front.sv @@
module mmec_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic signed [SAMPLE_BITS-1:0]       mid_sample,
   input  logic signed [SAMPLE_BITS-1:0]       side_sample,
   input  logic [mmec_pkg::COUNT_W-1:0]        samples_per_column,
   input  logic [mmec_pkg::COLCOUNT_W-1:0]     column_count,
   input  mmec_pkg::mode_type                  mode,
   output logic                                push_valid,
   output logic [4*(SAMPLE_BITS+1)+mmec_pkg::COL_W-1:0] push_data
);

   localparam int TW = SAMPLE_BITS + 1;
   localparam logic signed [TW-1:0] MIN_RESET = {1'b0, {SAMPLE_BITS{1'b1}}};
   localparam logic signed [TW-1:0] MAX_RESET = {1'b1, {SAMPLE_BITS{1'b0}}};

   logic signed [TW-1:0] pmin_ff, pmin_in, pmax_ff, pmax_in;
   logic signed [TW-1:0] smin_ff, smin_in, smax_ff, smax_in;
   logic [mmec_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [mmec_pkg::COL_W-1:0]   pos_ff, pos_in;

   logic signed [TW-1:0] mid_x, side_x, p_val, s_val;
   logic signed [TW-1:0] pmin_new, pmax_new, smin_new, smax_new;
   logic [mmec_pkg::COUNT_W-1:0]    count_next, spc_eff;
   logic [mmec_pkg::COLCOUNT_W-1:0] cc_eff, pos_inc;
   logic [mmec_pkg::COL_W-1:0]      pos_cur;
   logic                            col_end;

   always_comb begin
      mid_x  = {mid_sample[SAMPLE_BITS-1], mid_sample};
      side_x = {side_sample[SAMPLE_BITS-1], side_sample};
      if (mode.left_right) begin
         p_val = mid_x + side_x;
         s_val = mid_x - side_x;
      end else begin
         p_val = mid_x;
         s_val = side_x;
      end
      pmin_new = (p_val < pmin_ff) ? p_val : pmin_ff;
      pmax_new = (p_val > pmax_ff) ? p_val : pmax_ff;
      smin_new = (s_val < smin_ff) ? s_val : smin_ff;
      smax_new = (s_val > smax_ff) ? s_val : smax_ff;

      // The count wraps at its width; a wrap also closes the column.
      count_next = count_ff + 1'b1;
      spc_eff    = (samples_per_column == '0) ? mmec_pkg::COUNT_W'(1) : samples_per_column;
      col_end    = (count_next == '0) || (count_next >= spc_eff);

      if (column_count == '0) begin
         cc_eff = mmec_pkg::COLCOUNT_W'(1);
      end else if (column_count > mmec_pkg::MAX_COLUMNS) begin
         cc_eff = mmec_pkg::MAX_COLUMNS;
      end else begin
         cc_eff = column_count;
      end
      pos_cur = ({1'b0, pos_ff} >= cc_eff) ? '0 : pos_ff;
      pos_inc = {1'b0, pos_cur} + 1'b1;

      pmin_in  = pmin_ff;
      pmax_in  = pmax_ff;
      smin_in  = smin_ff;
      smax_in  = smax_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (fire) begin
         if (col_end) begin
            pmin_in  = MIN_RESET;
            pmax_in  = MAX_RESET;
            smin_in  = MIN_RESET;
            smax_in  = MAX_RESET;
            count_in = '0;
            pos_in   = (pos_inc >= cc_eff) ? '0 : pos_inc[mmec_pkg::COL_W-1:0];
         end else begin
            pmin_in  = pmin_new;
            pmax_in  = pmax_new;
            smin_in  = smin_new;
            smax_in  = smax_new;
            count_in = count_next;
         end
      end
   end

   assign push_valid = fire && col_end;
   assign push_data  = {pos_cur, smax_new, smin_new, pmax_new, pmin_new};

   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff  <= MIN_RESET;
         pmax_ff  <= MAX_RESET;
         smin_ff  <= MIN_RESET;
         smax_ff  <= MAX_RESET;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         pmin_ff  <= pmin_in;
         pmax_ff  <= pmax_in;
         smin_ff  <= smin_in;
         smax_ff  <= smax_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

@@ rtl/mmec_queue.sv @@
module mmec_queue #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign not_full  = (count_ff != CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/mmec_back.sv @@
module mmec_back #(
   parameter int SAMPLE_BITS = 16,
   parameter int ROW_BITS    = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  logic [4*(SAMPLE_BITS+1)+mmec_pkg::COL_W-1:0] q_data,
   output logic                                q_pop,
   input  logic [mmec_pkg::ROWCOUNT_W-1:0]     row_count,
   input  mmec_pkg::mode_type                  mode,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mmec_pkg::COL_W-1:0]          rsp_column_index,
   output logic                                rsp_primary_drawn,
   output logic [ROW_BITS-1:0]                 rsp_primary_row_low,
   output logic [ROW_BITS-1:0]                 rsp_primary_row_high,
   output logic                                rsp_secondary_drawn,
   output logic [ROW_BITS-1:0]                 rsp_secondary_row_low,
   output logic [ROW_BITS-1:0]                 rsp_secondary_row_high
);

   localparam int TW = SAMPLE_BITS + 1;
   localparam int HW = ROW_BITS + 1;
   localparam int CW = (HW > mmec_pkg::ROWCOUNT_W) ? HW : mmec_pkg::ROWCOUNT_W;
   localparam int PW = TW + ROW_BITS;
   localparam logic signed [TW-1:0] POS_FULL = {2'b01, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [TW-1:0] NEG_FULL = {2'b11, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [PW-1:0] ROUND_HALF =
      {{(ROW_BITS+1){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Stage 1: clamped offsets and per-trace row ranges.
   logic                       s1_valid_ff, s1_valid_in;
   logic [TW-1:0]              u1_ff [4];
   logic [ROW_BITS-1:0]        d1_ff [2];
   logic [ROW_BITS-1:0]        lo1_ff [2];
   logic [1:0]                 drawn1_ff;
   logic [mmec_pkg::COL_W-1:0] pos1_ff;

   // Stage 2: products.
   logic                       s2_valid_ff, s2_valid_in;
   logic [PW-1:0]              prod2_ff [4];
   logic [ROW_BITS-1:0]        lo2_ff [2];
   logic [1:0]                 drawn2_ff;
   logic [mmec_pkg::COL_W-1:0] pos2_ff;

   // Stage 3: output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ROW_BITS-1:0]        row3_ff [4];
   logic [1:0]                 drawn3_ff;
   logic [mmec_pkg::COL_W-1:0] pos3_ff;

   logic s1_ready, s2_ready, s3_ready;

   logic signed [TW-1:0]  ext [4];
   logic signed [TW-1:0]  clamped [4];
   logic [TW-1:0]         u_next [4];
   logic [CW-1:0]         rc_ext, rc_limit;
   logic [HW-1:0]         h, h_m1, p_span;
   logic [ROW_BITS-1:0]   half, p_d, s_d, p_lo;
   logic                  h_empty;
   logic [1:0]            drawn_next;
   logic [PW-1:0]         prod_next [4];
   logic [PW-1:0]         rounded [4];
   logic [ROW_BITS-1:0]   row_next [4];

   assign s3_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign q_pop    = q_valid && s1_ready;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ext[k] = q_data[k*TW +: TW];
         if (ext[k] < NEG_FULL) begin
            clamped[k] = NEG_FULL;
         end else if (ext[k] > POS_FULL) begin
            clamped[k] = POS_FULL;
         end else begin
            clamped[k] = ext[k];
         end
         u_next[k] = clamped[k] + POS_FULL;
      end

      rc_ext   = CW'(row_count);
      rc_limit = CW'(1) << ROW_BITS;
      h        = (rc_ext > rc_limit) ? rc_limit[HW-1:0] : rc_ext[HW-1:0];
      h_m1     = h - 1'b1;
      half     = h[HW-1:1];
      h_empty  = (h == '0);
      p_span   = h_m1 - {1'b0, half};

      // Stereo puts the primary trace in the upper half of the column.
      if (mode.stereo) begin
         p_lo = half;
         p_d  = p_span[ROW_BITS-1:0];
         s_d  = (half == '0) ? '0 : half - 1'b1;
      end else begin
         p_lo = '0;
         p_d  = h_m1[ROW_BITS-1:0];
         s_d  = '0;
      end

      drawn_next[0] = !h_empty && ((ext[0] != ext[1]) || mode.flat_enable);
      drawn_next[1] = mode.stereo && ((ext[2] != ext[3]) || mode.flat_enable);

      for (int k = 0; k < 4; k++) begin
         prod_next[k] = u1_ff[k] * d1_ff[k >> 1];
         rounded[k]   = prod2_ff[k] + ROUND_HALF;
         row_next[k]  = drawn2_ff[k >> 1]
                        ? lo2_ff[k >> 1] + rounded[k][SAMPLE_BITS +: ROW_BITS]
                        : '0;
      end

      s1_valid_in  = q_pop ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);
      s2_valid_in  = (s1_valid_ff && s2_ready) ? 1'b1 : (s3_ready ? 1'b0 : s2_valid_ff);
      rsp_valid_in = (s2_valid_ff && s3_ready) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int k = 0; k < 4; k++) begin
            u1_ff[k] <= u_next[k];
         end
         d1_ff[0]  <= p_d;
         d1_ff[1]  <= s_d;
         lo1_ff[0] <= p_lo;
         lo1_ff[1] <= '0;
         drawn1_ff <= drawn_next;
         pos1_ff   <= q_data[4*TW +: mmec_pkg::COL_W];
      end
      if (s1_valid_ff && s2_ready) begin
         for (int k = 0; k < 4; k++) begin
            prod2_ff[k] <= prod_next[k];
         end
         lo2_ff    <= lo1_ff;
         drawn2_ff <= drawn1_ff;
         pos2_ff   <= pos1_ff;
      end
      if (s2_valid_ff && s3_ready) begin
         for (int k = 0; k < 4; k++) begin
            row3_ff[k] <= row_next[k];
         end
         drawn3_ff <= drawn2_ff;
         pos3_ff   <= pos2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_column_index       = pos3_ff;
   assign rsp_primary_drawn      = drawn3_ff[0];
   assign rsp_primary_row_low    = row3_ff[0];
   assign rsp_primary_row_high   = row3_ff[1];
   assign rsp_secondary_drawn    = drawn3_ff[1];
   assign rsp_secondary_row_low  = row3_ff[2];
   assign rsp_secondary_row_high = row3_ff[3];

endmodule
